@@ rtl/h2s_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP/2 stream tracker package
// Word types, event and status codes, stream phases and default limits.
// ----------------------------------------------------------------------------
package h2s_pkg;

   localparam int WIN_WIDTH       = 31;
   localparam int ID_WIDTH        = 31;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam int unsigned MAX_WINDOW_DEFAULT   = 32'd2147483647;
   localparam int unsigned RESET_WINDOW_DEFAULT = 32'd65535;
   localparam logic [WIN_WIDTH-1:0] INIT_WINDOW_RESET = 31'd65535;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INIT_LOCAL  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INIT_REMOTE = 1'b1;

   typedef enum logic [3:0] {
      KIND_SEND_HDR   = 4'd0,
      KIND_SEND_DATA  = 4'd1,
      KIND_RECV_HDR   = 4'd2,
      KIND_RECV_DATA  = 4'd3,
      KIND_REMOTE_UPD = 4'd4,
      KIND_LOCAL_UPD  = 4'd5,
      KIND_INIT       = 4'd6,
      KIND_CLOSE      = 4'd7,
      KIND_RESET      = 4'd8
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_STATE = 3'd1,
      STATUS_SEND_WIN  = 3'd2,
      STATUS_FLOW      = 3'd3,
      STATUS_ZERO_INC  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PHASE_IDLE   = 3'd0,
      PHASE_OPEN   = 3'd1,
      PHASE_HCL    = 3'd2,
      PHASE_HCR    = 3'd3,
      PHASE_CLOSED = 3'd4
   } phase_type;

   typedef struct packed {
      logic [3:0]           kind;
      logic                 end_stream;
      logic [WIN_WIDTH-1:0] amount;
      logic [ID_WIDTH-1:0]  new_stream_id;
   } req_word_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [2:0]           stream_state;
      logic [WIN_WIDTH-1:0] local_window_out;
      logic [WIN_WIDTH-1:0] remote_window_out;
      logic [ID_WIDTH-1:0]  stream_id_out;
   } rsp_word_type;

endpackage

@@ rtl/h2s_engine.sv @@
// ----------------------------------------------------------------------------
// HTTP/2 stream event engine
// Holds the stream phase, both windows, the stream id and the init window
// registers, and applies one event per cycle while process is high.
// ----------------------------------------------------------------------------
module h2s_engine import h2s_pkg::*; #(
   parameter int unsigned MAX_WINDOW   = MAX_WINDOW_DEFAULT,
   parameter int unsigned RESET_WINDOW = RESET_WINDOW_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WIN_WIDTH-1:0]       csr_data,
   input  logic                       process,
   input  req_word_type               event_word,
   output rsp_word_type               result_word
);

   phase_type            phase_ff, phase_in;
   logic [WIN_WIDTH-1:0] recv_window_ff, recv_window_in;
   logic [WIN_WIDTH-1:0] send_window_ff, send_window_in;
   logic [ID_WIDTH-1:0]  stream_id_ff, stream_id_in;
   logic [WIN_WIDTH-1:0] init_local_ff, init_remote_ff;

   kind_type             kind;
   status_type           status;
   phase_type            near_half, far_half;
   logic                 is_send;
   logic [WIN_WIDTH-1:0] sel_window;
   logic [WIN_WIDTH-1:0] diff_window;
   logic [WIN_WIDTH:0]   sum_window;
   logic                 amount_over;
   logic                 sum_over;
   logic                 amount_zero;

   assign kind = kind_type'(event_word.kind);

   // The sending side of a header or data word decides which half closed
   // state it moves toward.
   assign is_send   = (kind == KIND_SEND_HDR) || (kind == KIND_SEND_DATA) ||
                      (kind == KIND_REMOTE_UPD);
   assign near_half = is_send ? PHASE_HCL : PHASE_HCR;
   assign far_half  = is_send ? PHASE_HCR : PHASE_HCL;

   assign sel_window  = is_send ? send_window_ff : recv_window_ff;
   assign diff_window = sel_window - event_word.amount;
   assign sum_window  = {1'b0, sel_window} + {1'b0, event_word.amount};
   assign amount_over = event_word.amount > sel_window;
   assign sum_over    = {1'b0, sum_window} > 33'(MAX_WINDOW);
   assign amount_zero = event_word.amount == '0;

   always_comb begin
      status         = STATUS_OK;
      phase_in       = phase_ff;
      recv_window_in = recv_window_ff;
      send_window_in = send_window_ff;
      stream_id_in   = stream_id_ff;
      case (kind) inside
         KIND_SEND_HDR, KIND_RECV_HDR: begin
            if (phase_ff == PHASE_IDLE) begin
               phase_in = event_word.end_stream ? near_half : PHASE_OPEN;
            end else if (phase_ff == PHASE_OPEN) begin
               if (event_word.end_stream) phase_in = near_half;
            end else if (phase_ff == far_half) begin
               if (event_word.end_stream) phase_in = PHASE_CLOSED;
            end else begin
               status = STATUS_BAD_STATE;
            end
         end
         KIND_SEND_DATA, KIND_RECV_DATA: begin
            if (phase_ff != PHASE_OPEN && phase_ff != far_half) begin
               status = STATUS_BAD_STATE;
            end else if (amount_over) begin
               status = is_send ? STATUS_SEND_WIN : STATUS_FLOW;
            end else begin
               if (is_send) send_window_in = diff_window;
               else         recv_window_in = diff_window;
               if (event_word.end_stream) begin
                  phase_in = (phase_ff == far_half) ? PHASE_CLOSED : near_half;
               end
            end
         end
         KIND_REMOTE_UPD, KIND_LOCAL_UPD: begin
            if (amount_zero) begin
               status = STATUS_ZERO_INC;
            end else if (sum_over) begin
               status = STATUS_FLOW;
            end else if (is_send) begin
               send_window_in = sum_window[WIN_WIDTH-1:0];
            end else begin
               recv_window_in = sum_window[WIN_WIDTH-1:0];
            end
         end
         KIND_INIT: begin
            stream_id_in   = event_word.new_stream_id;
            phase_in       = PHASE_IDLE;
            recv_window_in = init_local_ff;
            send_window_in = init_remote_ff;
         end
         KIND_CLOSE: begin
            phase_in = PHASE_CLOSED;
         end
         KIND_RESET: begin
            stream_id_in   = '0;
            phase_in       = PHASE_IDLE;
            recv_window_in = WIN_WIDTH'(RESET_WINDOW);
            send_window_in = WIN_WIDTH'(RESET_WINDOW);
         end
         default: begin
            status = STATUS_BAD_STATE;
         end
      endcase
   end

   always_comb begin
      result_word.status            = status;
      result_word.stream_state      = phase_in;
      result_word.local_window_out  = recv_window_in;
      result_word.remote_window_out = send_window_in;
      result_word.stream_id_out     = stream_id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_IDLE;
         recv_window_ff <= WIN_WIDTH'(RESET_WINDOW_DEFAULT);
         send_window_ff <= WIN_WIDTH'(RESET_WINDOW_DEFAULT);
         stream_id_ff   <= '0;
         init_local_ff  <= INIT_WINDOW_RESET;
         init_remote_ff <= INIT_WINDOW_RESET;
      end else begin
         if (process) begin
            phase_ff       <= phase_in;
            recv_window_ff <= recv_window_in;
            send_window_ff <= send_window_in;
            stream_id_ff   <= stream_id_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_INIT_LOCAL:  init_local_ff  <= csr_data;
               CSR_INIT_REMOTE: init_remote_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

@@ rtl/http2_stream_state_and_window.sv @@
// ----------------------------------------------------------------------------
// HTTP/2 stream state and flow-control window tracker
// Follows one stream through its states and keeps its send and receive
// windows; every event word returns one status word.
//
// Usage:
//   Event words enter on the req_ channel (valid/stall) and each gives
//   exactly one result word on the rsp_ channel, in order. An accepted word
//   is evaluated from the input register and its result is loaded into the
//   result register that drives rsp_valid. One word per cycle is sustained
//   while rsp_stall is low: the event logic between the two registers is
//   the window compares, one add or subtract and the phase update.
//   When the receiver asserts rsp_stall the result register holds its word;
//   one more event word can wait in the input register, after which
//   req_stall rises until the result is taken.
//   The csr_ port writes the init windows (index 0 receive, index 1 send);
//   write only while no word is in flight.
//   Reset (synchronous, active high) empties both registers, sets the phase
//   to idle, both windows to 65535, the stream id to zero and both init
//   windows to 65535.
// ----------------------------------------------------------------------------
module http2_stream_state_and_window import h2s_pkg::*; #(
   parameter int unsigned MAX_WINDOW   = MAX_WINDOW_DEFAULT,
   parameter int unsigned RESET_WINDOW = RESET_WINDOW_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_word_type               req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_word_type               rsp_word,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WIN_WIDTH-1:0]       csr_data
);

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   rsp_word_type result_word;
   logic         advance;
   logic         take;

   // The held event word moves on when the result register is free or is
   // being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   h2s_engine #(
      .MAX_WINDOW   (MAX_WINDOW),
      .RESET_WINDOW (RESET_WINDOW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .process     (advance),
      .event_word  (in_word_ff),
      .result_word (result_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (take)    in_word_ff  <= req_word;
      if (advance) out_word_ff <= result_word;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

`ifndef SYNTHESIS
   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held event word was dropped");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> in_valid_ff)
      else $error("accepted event word not registered");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid && rsp_word == $past(result_word)))
      else $error("evaluated event did not reach the result register");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stalled with an empty input register");
`endif

endmodule
